@@ hdl/mxfr_pkg.sv @@
// ----------------------------------------------------------------------------
// mxfr_pkg
// Shared types and constants for the sync-word framed receiver with XOR
// checksum.
// ----------------------------------------------------------------------------
package mxfr_pkg;

  // Fixed field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned SYNC_W   = 64;
  localparam int unsigned FLEN_W   = 6;
  localparam int unsigned BIDX_W   = 5;
  localparam int unsigned STATUS_W = 2;

  // Saturation value for an overlong length byte
  localparam logic [FLEN_W-1:0] FLEN_SAT = '1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_GOOD     = 2'd0,
    ST_CSUM_ERR = 2'd1,
    ST_LEN_ERR  = 2'd2
  } status_e;

  // One result word as held in the output register
  typedef struct packed {
    status_e             status;
    logic [BYTE_W-1:0]   command;
    logic [FLEN_W-1:0]   frame_length;
    logic [BIDX_W-1:0]   byte_index;
    logic [BYTE_W-1:0]   data_byte;
    logic                has_data;
    logic                last;
  } out_word_t;

endpackage : mxfr_pkg

@@ hdl/magic_xor_frame_receiver_top.sv @@
// ----------------------------------------------------------------------------
// magic_xor_frame_receiver_top
// Hunts for a configurable sync word, parses command, length, payload and
// XOR checksum, and emits a good frame one payload byte per output word.
//
//  Channel | Direction | Handshake            | Word
//  --------+-----------+----------------------+------------------------------
//  in      | input     | in_valid_i/in_stall_o  | rx_byte_i
//  out     | output    | out_valid_o/out_stall_i| status, command, length,
//          |           |                      | index, data, has_data, last
//  cfg     | input     | cfg_valid_i/cfg_ready_o| sync_word_i
//
//  An input byte is taken when the output register is free and no readback
//  is under way. A good frame stalls the input while its payload is read
//  back from the RAM (registered read data, then one word a cycle); a
//  stalled output stretches this. Reset is asynchronous, active low, and
//  returns the parser to sync hunting; the payload RAM needs no clearing.
// ----------------------------------------------------------------------------
module magic_xor_frame_receiver_top #(
  parameter int unsigned MAX_PAYLOAD = 32,
  parameter int unsigned SYNC_BYTES  = 8
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Configuration
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [mxfr_pkg::SYNC_W-1:0]            sync_word_i,
  // Input bytes
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [mxfr_pkg::BYTE_W-1:0]            rx_byte_i,
  // Results
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output mxfr_pkg::status_e                      status_o,
  output logic [mxfr_pkg::BYTE_W-1:0]            command_o,
  output logic [mxfr_pkg::FLEN_W-1:0]            frame_length_o,
  output logic [mxfr_pkg::BIDX_W-1:0]            byte_index_o,
  output logic [mxfr_pkg::BYTE_W-1:0]            data_byte_o,
  output logic                                   has_data_o,
  output logic                                   last_o
);

  import mxfr_pkg::*;

  // Derived widths
  localparam int unsigned AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int unsigned LEN_W = ($clog2(MAX_PAYLOAD + 1) > FLEN_W) ?
                                  $clog2(MAX_PAYLOAD + 1) : FLEN_W;
  localparam int unsigned CNT_W = (SYNC_BYTES > 1) ? $clog2(SYNC_BYTES) : 1;

  // Parser phases
  localparam logic [2:0] PH_HUNT  = 3'd0;
  localparam logic [2:0] PH_CMD   = 3'd1;
  localparam logic [2:0] PH_LEN   = 3'd2;
  localparam logic [2:0] PH_DATA  = 3'd3;
  localparam logic [2:0] PH_CHECK = 3'd4;
  localparam logic [2:0] PH_EMIT  = 3'd5;

  // Control state
  logic [2:0]        phase_q, phase_d;
  logic [CNT_W-1:0]  sync_cnt_q, sync_cnt_d;
  logic [BYTE_W-1:0] cmd_q, cmd_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [LEN_W-1:0]  fill_q, fill_d;
  logic [BYTE_W-1:0] xor_q, xor_d;
  logic [SYNC_W-1:0] sync_q;
  logic [LEN_W-1:0]  nxt_q, nxt_d;
  logic [LEN_W-1:0]  rd_idx_q, rd_idx_d;
  logic              rd_pend_q, rd_pend_d;
  logic              out_valid_q, out_valid_d;
  out_word_t         out_q, out_d;

  // Datapath signals
  logic              in_acc;
  logic              out_free;
  logic              load_now;
  logic              issue;
  logic              emit_last;
  logic [2:0]        sync_sel;
  logic [BYTE_W-1:0] sync_byte;
  logic              ram_we;
  logic [BYTE_W-1:0] ram_rdata;
  logic [FLEN_W-1:0] len_sat;

  // Handshakes
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (phase_q == PH_EMIT) || !out_free;
  assign in_acc      = in_valid_i && !in_stall_o;

  // Sync byte at the current hunt position
  assign sync_sel  = 3'(sync_cnt_q);
  assign sync_byte = sync_q[{sync_sel, 3'b000} +: BYTE_W];

  // Overlong length saturates at the field maximum
  assign len_sat = (rx_byte_i > BYTE_W'(FLEN_SAT)) ? FLEN_SAT : FLEN_W'(rx_byte_i);

  // Readback sequencer: a read is in flight, load it when the output is free
  assign load_now  = rd_pend_q && out_free;
  assign issue     = (phase_q == PH_EMIT) && (nxt_q < len_q) && (!rd_pend_q || load_now);
  assign emit_last = (rd_idx_q + 1'b1) == len_q;
  assign ram_we    = in_acc && (phase_q == PH_DATA);

  // Payload store
  mxfr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_PAYLOAD)
  ) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (fill_q[AW-1:0]),
    .wdata_i (rx_byte_i),
    .re_i    (issue),
    .raddr_i (nxt_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Parser and output register next state
  always_comb begin
    phase_d     = phase_q;
    sync_cnt_d  = sync_cnt_q;
    cmd_d       = cmd_q;
    len_d       = len_q;
    fill_d      = fill_q;
    xor_d       = xor_q;
    nxt_d       = nxt_q;
    rd_idx_d    = rd_idx_q;
    rd_pend_d   = rd_pend_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    if (in_acc) begin
      case (phase_q)
        PH_HUNT: begin
          if (rx_byte_i == sync_byte) begin
            if (sync_cnt_q == CNT_W'(SYNC_BYTES - 1)) begin
              sync_cnt_d = '0;
              phase_d    = PH_CMD;
            end else begin
              sync_cnt_d = sync_cnt_q + 1'b1;
            end
          end else begin
            sync_cnt_d = (rx_byte_i == sync_q[BYTE_W-1:0]) ? CNT_W'(1) : '0;
          end
        end
        PH_CMD: begin
          cmd_d   = rx_byte_i;
          xor_d   = rx_byte_i;
          phase_d = PH_LEN;
        end
        PH_LEN: begin
          xor_d  = xor_q ^ rx_byte_i;
          fill_d = '0;
          if (rx_byte_i == '0) begin
            len_d   = '0;
            phase_d = PH_CHECK;
          end else if (rx_byte_i <= BYTE_W'(MAX_PAYLOAD)) begin
            len_d   = LEN_W'(rx_byte_i);
            phase_d = PH_DATA;
          end else begin
            // overlong: report and resume hunting
            len_d               = LEN_W'(len_sat);
            out_valid_d         = 1'b1;
            out_d.status        = ST_LEN_ERR;
            out_d.command       = cmd_q;
            out_d.frame_length  = len_sat;
            out_d.byte_index    = '0;
            out_d.data_byte     = '0;
            out_d.has_data      = 1'b0;
            out_d.last          = 1'b1;
            phase_d             = PH_HUNT;
          end
        end
        PH_DATA: begin
          xor_d  = xor_q ^ rx_byte_i;
          fill_d = fill_q + 1'b1;
          if ((fill_q + 1'b1) >= len_q) begin
            phase_d = PH_CHECK;
          end
        end
        PH_CHECK: begin
          phase_d = PH_HUNT;
          if (rx_byte_i == xor_q) begin
            if (len_q == '0) begin
              out_valid_d        = 1'b1;
              out_d.status       = ST_GOOD;
              out_d.command      = cmd_q;
              out_d.frame_length = '0;
              out_d.byte_index   = '0;
              out_d.data_byte    = '0;
              out_d.has_data     = 1'b0;
              out_d.last         = 1'b1;
            end else begin
              nxt_d     = '0;
              rd_pend_d = 1'b0;
              phase_d   = PH_EMIT;
            end
          end else begin
            out_valid_d        = 1'b1;
            out_d.status       = ST_CSUM_ERR;
            out_d.command      = cmd_q;
            out_d.frame_length = FLEN_W'(len_q);
            out_d.byte_index   = '0;
            out_d.data_byte    = '0;
            out_d.has_data     = 1'b0;
            out_d.last         = 1'b1;
          end
        end
        default: begin
          phase_d = PH_HUNT;
        end
      endcase
    end

    // Payload readback
    if (load_now) begin
      rd_pend_d          = 1'b0;
      out_valid_d        = 1'b1;
      out_d.status       = ST_GOOD;
      out_d.command      = cmd_q;
      out_d.frame_length = FLEN_W'(len_q);
      out_d.byte_index   = BIDX_W'(rd_idx_q);
      out_d.data_byte    = ram_rdata;
      out_d.has_data     = 1'b1;
      out_d.last         = emit_last;
      if (emit_last) begin
        phase_d = PH_HUNT;
      end
    end
    if (issue) begin
      rd_pend_d = 1'b1;
      rd_idx_d  = nxt_q;
      nxt_d     = nxt_q + 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      sync_cnt_q  <= '0;
      cmd_q       <= '0;
      len_q       <= '0;
      fill_q      <= '0;
      xor_q       <= '0;
      sync_q      <= '0;
      nxt_q       <= '0;
      rd_idx_q    <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      sync_cnt_q  <= sync_cnt_d;
      cmd_q       <= cmd_d;
      len_q       <= len_d;
      fill_q      <= fill_d;
      xor_q       <= xor_d;
      nxt_q       <= nxt_d;
      rd_idx_q    <= rd_idx_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        sync_q <= sync_word_i;
      end
    end
  end

  // Output word register
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_q.status;
  assign command_o      = out_q.command;
  assign frame_length_o = out_q.frame_length;
  assign byte_index_o   = out_q.byte_index;
  assign data_byte_o    = out_q.data_byte;
  assign has_data_o     = out_q.has_data;
  assign last_o         = out_q.last;

  // Checks
  a_pend_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> phase_q == PH_EMIT)
    else $error("read pending outside readback");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> (fill_q < len_q) && (len_q <= LEN_W'(MAX_PAYLOAD)))
    else $error("fill index beyond frame length");

  a_sync_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sync_cnt_q <= CNT_W'(SYNC_BYTES - 1))
    else $error("sync count out of range");

  a_last_ends_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_now && emit_last |=> phase_q == PH_HUNT && out_valid_q && !rd_pend_q)
    else $error("readback did not end on last word");

  a_issue_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue && rd_pend_q |-> out_free)
    else $error("read issued over an unloaded word");

endmodule : magic_xor_frame_receiver_top

@@ hdl/mxfr_ram.sv @@
// ----------------------------------------------------------------------------
// mxfr_ram
// Generic single-write, single-read RAM with registered read data. Read
// data holds its value between read enables.
// ----------------------------------------------------------------------------
module mxfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule : mxfr_ram

@@ bench/magic_xor_frame_receiver_top_tb.sv @@
// ----------------------------------------------------------------------------
// magic_xor_frame_receiver_top_tb
// Self-checking bench for the sync-word framed receiver. A directed table
// covers the reset sync word, a zero-length frame, a saturated overlong
// length and a checksum error. Random traffic follows, mostly well-formed
// frames with random content plus broken sync runs and line noise, under
// several sync words and idle patterns. Every output word is checked
// against the directed table's expected word or an in-bench frame parser.
// ----------------------------------------------------------------------------
module magic_xor_frame_receiver_top_tb;
  import mxfr_pkg::*;

  localparam int unsigned MAX_PAYLOAD   = 32;
  localparam int unsigned SYNC_BYTES    = 8;
  localparam int          PHASE_BYTES   = 60;
  localparam int          HOLD_CYCLES   = 200;
  localparam int          SETTLE_CYCLES = 16;
  localparam int          CYCLE_LIMIT   = 1000000;

  // Parser phases of the frame model
  typedef enum logic [2:0] {
    PARSE_HUNT,
    PARSE_CMD,
    PARSE_LEN,
    PARSE_DATA,
    PARSE_CHECK
  } parse_phase_e;

  // One directed row: input byte, plus a typed expected word where obvious
  typedef struct packed {
    logic [BYTE_W-1:0] rx;
    logic              typed;
    out_word_t         word;
  } dir_row_t;

  localparam out_word_t NO_WORD   = '0;
  localparam out_word_t GOOD_HDR  = '{ST_GOOD, 8'hFF, 6'd0, 5'd0, 8'h00, 1'b0, 1'b1};
  localparam out_word_t LEN_SAT   = '{ST_LEN_ERR, 8'h00, FLEN_SAT, 5'd0, 8'h00, 1'b0, 1'b1};
  localparam out_word_t CSUM_FAIL = '{ST_CSUM_ERR, 8'h80, 6'd0, 5'd0, 8'h00, 1'b0, 1'b1};

  localparam int DIR_N = 32;

  // Sync word is all zero after reset
  localparam dir_row_t DIR_TBL [DIR_N] = '{
    // zero-length frame, command 0xFF, good checksum
    '{8'h00, 1'b0, NO_WORD}, '{8'h00, 1'b0, NO_WORD}, '{8'h00, 1'b0, NO_WORD},
    '{8'h00, 1'b0, NO_WORD}, '{8'h00, 1'b0, NO_WORD}, '{8'h00, 1'b0, NO_WORD},
    '{8'h00, 1'b0, NO_WORD}, '{8'h00, 1'b0, NO_WORD},
    '{8'hFF, 1'b0, NO_WORD},
    '{8'h00, 1'b0, NO_WORD},
    '{8'hFF, 1'b1, GOOD_HDR},
    // length 0xFF saturates to 63, back to hunting without a checksum
    '{8'h00, 1'b0, NO_WORD}, '{8'h00, 1'b0, NO_WORD}, '{8'h00, 1'b0, NO_WORD},
    '{8'h00, 1'b0, NO_WORD}, '{8'h00, 1'b0, NO_WORD}, '{8'h00, 1'b0, NO_WORD},
    '{8'h00, 1'b0, NO_WORD}, '{8'h00, 1'b0, NO_WORD},
    '{8'h00, 1'b0, NO_WORD},
    '{8'hFF, 1'b1, LEN_SAT},
    // zero-length frame, command 0x80, wrong checksum
    '{8'h00, 1'b0, NO_WORD}, '{8'h00, 1'b0, NO_WORD}, '{8'h00, 1'b0, NO_WORD},
    '{8'h00, 1'b0, NO_WORD}, '{8'h00, 1'b0, NO_WORD}, '{8'h00, 1'b0, NO_WORD},
    '{8'h00, 1'b0, NO_WORD}, '{8'h00, 1'b0, NO_WORD},
    '{8'h80, 1'b0, NO_WORD},
    '{8'h00, 1'b0, NO_WORD},
    '{8'h00, 1'b1, CSUM_FAIL}
  };

  // DUT signals
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [SYNC_W-1:0]   sync_word_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic [BYTE_W-1:0]   rx_byte_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  status_e             status_o;
  logic [BYTE_W-1:0]   command_o;
  logic [FLEN_W-1:0]   frame_length_o;
  logic [BIDX_W-1:0]   byte_index_o;
  logic [BYTE_W-1:0]   data_byte_o;
  logic                has_data_o;
  logic                last_o;

  // Frame parser model state
  logic [SYNC_W-1:0]   sync_reg  = '0;
  parse_phase_e        parse_ph  = PARSE_HUNT;
  int                  sync_cnt  = 0;
  logic [BYTE_W-1:0]   cur_cmd   = '0;
  logic [FLEN_W-1:0]   cur_len   = '0;
  int                  fill_cnt  = 0;
  logic [BYTE_W-1:0]   xor_acc   = '0;
  logic [BYTE_W-1:0]   pay_buf [MAX_PAYLOAD];

  out_word_t           new_words [$];   // words caused by the last byte
  out_word_t           frame_words [$]; // words still owed by the DUT

  bit                  tx_idle_on = 1'b1;
  bit                  rx_idle_on = 1'b1;
  bit                  hold_req   = 1'b0;
  int                  err_cnt    = 0;
  int                  cycle_cnt  = 0;

  magic_xor_frame_receiver_top #(
    .MAX_PAYLOAD(MAX_PAYLOAD),
    .SYNC_BYTES (SYNC_BYTES)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .sync_word_i   (sync_word_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .command_o     (command_o),
    .frame_length_o(frame_length_o),
    .byte_index_o  (byte_index_o),
    .data_byte_o   (data_byte_o),
    .has_data_o    (has_data_o),
    .last_o        (last_o)
  );

  // Clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap(input bit on);
    int r;
    r = $urandom_range(0, 99);
    if (!on || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void add_word(input status_e st, input logic [FLEN_W-1:0] len,
                                   input logic [BIDX_W-1:0] idx,
                                   input logic [BYTE_W-1:0] data,
                                   input logic has, input logic lst);
    out_word_t w;
    w.status       = st;
    w.command      = cur_cmd;
    w.frame_length = len;
    w.byte_index   = idx;
    w.data_byte    = data;
    w.has_data     = has;
    w.last         = lst;
    new_words.push_back(w);
  endfunction

  // Frame parser: advance on one byte, collect the words it causes
  function automatic void parse_byte(input logic [BYTE_W-1:0] b);
    int cnt;
    new_words.delete();
    case (parse_ph)
      PARSE_HUNT: begin
        if (b == sync_reg[(sync_cnt % 8)*8 +: 8]) begin
          sync_cnt++;
          if (sync_cnt >= SYNC_BYTES) begin
            sync_cnt = 0;
            parse_ph = PARSE_CMD;
          end
        end else begin
          sync_cnt = (b == sync_reg[7:0]) ? 1 : 0;
        end
      end
      PARSE_CMD: begin
        cur_cmd  = b;
        xor_acc  = b;
        parse_ph = PARSE_LEN;
      end
      PARSE_LEN: begin
        xor_acc  = xor_acc ^ b;
        fill_cnt = 0;
        if (b == 8'd0) begin
          cur_len  = '0;
          parse_ph = PARSE_CHECK;
        end else if (b <= MAX_PAYLOAD) begin
          cur_len  = b[FLEN_W-1:0];
          parse_ph = PARSE_DATA;
        end else begin
          cur_len  = (b > 8'd63) ? FLEN_SAT : b[FLEN_W-1:0];
          add_word(ST_LEN_ERR, cur_len, '0, '0, 1'b0, 1'b1);
          parse_ph = PARSE_HUNT;
        end
      end
      PARSE_DATA: begin
        if (fill_cnt < MAX_PAYLOAD) pay_buf[fill_cnt] = b;
        fill_cnt++;
        xor_acc = xor_acc ^ b;
        if (fill_cnt >= cur_len) parse_ph = PARSE_CHECK;
      end
      PARSE_CHECK: begin
        if (b == xor_acc) begin
          if (cur_len == 0) begin
            add_word(ST_GOOD, '0, '0, '0, 1'b0, 1'b1);
          end else begin
            cnt = (cur_len > MAX_PAYLOAD) ? MAX_PAYLOAD : cur_len;
            for (int k = 0; k < cnt; k++)
              add_word(ST_GOOD, cur_len, k[BIDX_W-1:0], pay_buf[k], 1'b1, k + 1 == cnt);
          end
        end else begin
          add_word(ST_CSUM_ERR, cur_len, '0, '0, 1'b0, 1'b1);
        end
        parse_ph = PARSE_HUNT;
      end
      default: parse_ph = PARSE_HUNT;
    endcase
  endfunction

  // Offer one byte, log the expected words on acceptance, then maybe idle
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic typed = 1'b0,
                           input out_word_t word = '0);
    int g;
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    parse_byte(b);
    if (typed) frame_words.push_back(word);
    else foreach (new_words[i]) frame_words.push_back(new_words[i]);
    g = pick_gap(tx_idle_on);
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  // Stop offering, wait for every owed word, let trailing work finish
  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    while (frame_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_sync(input logic [SYNC_W-1:0] w);
    cfg_valid_i <= 1'b1;
    sync_word_i <= w;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sync_reg = w;
  endtask

  // Random traffic: well-formed frames, broken sync runs and noise
  task automatic run_traffic(input int target);
    int sent, r, len, k;
    logic [BYTE_W-1:0] cmd, x, b;
    sent = 0;
    while (sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        for (k = 0; k < SYNC_BYTES; k++) send_byte(sync_reg[k*8 +: 8]);
        cmd = 8'($urandom);
        r   = $urandom_range(0, 99);
        if (r < 8) len = 0;
        else if (r < 14) len = MAX_PAYLOAD;
        else if (r < 20) len = $urandom_range(MAX_PAYLOAD + 1, 255);
        else if (r < 30) len = $urandom_range(9, MAX_PAYLOAD - 1);
        else len = $urandom_range(1, 8);
        send_byte(cmd);
        send_byte(len[BYTE_W-1:0]);
        sent += SYNC_BYTES + 2;
        if (len <= MAX_PAYLOAD) begin
          x = cmd ^ len[BYTE_W-1:0];
          for (k = 0; k < len; k++) begin
            b = 8'($urandom);
            x = x ^ b;
            send_byte(b);
          end
          // one frame in ten gets a single flipped checksum bit
          if ($urandom_range(0, 9) == 0) x = x ^ (8'h01 << $urandom_range(0, 7));
          send_byte(x);
          sent += len + 1;
        end
      end else if (r < 88) begin
        // partial sync, then either the first sync byte again or junk
        k = $urandom_range(1, SYNC_BYTES - 1);
        for (int i = 0; i < k; i++) send_byte(sync_reg[i*8 +: 8]);
        if ($urandom_range(0, 1) == 1) send_byte(sync_reg[7:0]);
        else send_byte(8'($urandom));
        sent += k + 1;
      end else begin
        r = $urandom_range(1, 4);
        repeat (r) send_byte(8'($urandom));
        sent += r;
      end
    end
  endtask

  // Receiver stall pattern; a requested hold-off is counted here
  initial begin
    int  n;
    bit  doing_hold;
    forever begin
      doing_hold = hold_req;
      n = doing_hold ? HOLD_CYCLES : pick_gap(rx_idle_on);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      if (doing_hold) hold_req = 1'b0;
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  end

  // Output checker
  always @(posedge clk_i) begin
    out_word_t exp_w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (frame_words.size() == 0) begin
        $error("unexpected output word: status %0d command %0h", status_o, command_o);
        err_cnt++;
      end else begin
        exp_w = frame_words.pop_front();
        if (status_o !== exp_w.status) begin
          $error("status: expected %0d, actual %0d", exp_w.status, status_o);
          err_cnt++;
        end
        if (command_o !== exp_w.command) begin
          $error("command: expected %0h, actual %0h", exp_w.command, command_o);
          err_cnt++;
        end
        if (frame_length_o !== exp_w.frame_length) begin
          $error("frame_length: expected %0d, actual %0d", exp_w.frame_length,
                 frame_length_o);
          err_cnt++;
        end
        if (byte_index_o !== exp_w.byte_index) begin
          $error("byte_index: expected %0d, actual %0d", exp_w.byte_index, byte_index_o);
          err_cnt++;
        end
        if (data_byte_o !== exp_w.data_byte) begin
          $error("data_byte: expected %0h, actual %0h", exp_w.data_byte, data_byte_o);
          err_cnt++;
        end
        if (has_data_o !== exp_w.has_data) begin
          $error("has_data: expected %0b, actual %0b", exp_w.has_data, has_data_o);
          err_cnt++;
        end
        if (last_o !== exp_w.last) begin
          $error("last: expected %0b, actual %0b", exp_w.last, last_o);
          err_cnt++;
        end
      end
    end
  end

  // Main sequence
  initial begin
    logic [SYNC_W-1:0] w;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table against the reset sync word
    for (int i = 0; i < DIR_N; i++)
      send_byte(DIR_TBL[i].rx, DIR_TBL[i].typed, DIR_TBL[i].word);
    drain_and_settle();

    // random phases under different sync words and idle patterns
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0:       w = '1;
        3:       w = '0;
        default: w = {$urandom, $urandom};
      endcase
      write_sync(w);
      tx_idle_on = (ph % 2 == 0);
      rx_idle_on = (ph == 0 || ph >= 3);
      if (ph == 2) hold_req = 1'b1;
      run_traffic(PHASE_BYTES);
      drain_and_settle();
    end

    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule : magic_xor_frame_receiver_top_tb

@@ sim.f @@
hdl/mxfr_pkg.sv
hdl/mxfr_ram.sv
hdl/magic_xor_frame_receiver_top.sv
bench/magic_xor_frame_receiver_top_tb.sv
